// ----- design/sst_pkg.sv -----
// sst_pkg: shared types and codes for the sorted set table unit
// no dependencies; imported by sst_ctrl, sst_dp and sorted_set_table_unit
package sst_pkg;

  // fixed field widths
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 7;

  // operation codes of a request
  localparam logic [FUNC_W-1:0] FN_INSERT   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_DELETE   = 2'd1;
  localparam logic [FUNC_W-1:0] FN_CONTAINS = 2'd2;

  // status codes of a result
  localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd2;

  // datapath operations, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCAN_READ,
    OP_SCAN_STEP,
    OP_SCAN_HIT,
    OP_SCAN_END,
    OP_SET_FULL,
    OP_SET_MISS,
    OP_INS_INIT,
    OP_INS_READ,
    OP_INS_WRITE,
    OP_INS_PUT,
    OP_DEL_INIT,
    OP_DEL_READ,
    OP_DEL_WRITE,
    OP_DEL_END
  } dp_op_e;

  // controller to datapath
  typedef struct packed {
    dp_op_e op;
    logic   strobe;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic              scan_end;
    logic              less;
    logic              full;
    logic              found;
    logic              ins_more;
    logic              del_more;
    logic [FUNC_W-1:0] func;
  } dp_stat_t;

endpackage

// ----- design/sst_ctrl.sv -----
// sst_ctrl: request sequencer for the sorted set table unit
// depends on sst_pkg; drives sst_dp through dp_cmd_t and reads dp_stat_t
module sst_ctrl import sst_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  output dp_cmd_t  cmd_o,
  input  dp_stat_t stat_i
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_RD     = 9'b000000010,
    S_CMP    = 9'b000000100,
    S_DECIDE = 9'b000001000,
    S_INS_RD = 9'b000010000,
    S_INS_WR = 9'b000100000,
    S_DEL_RD = 9'b001000000,
    S_DEL_WR = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and datapath command
  always_comb begin
    state_d      = state_q;
    cmd_o.op     = OP_NONE;
    cmd_o.strobe = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_RD;
        end
      end
      S_RD: begin
        if (stat_i.scan_end) begin
          cmd_o.op = OP_SCAN_END;
          state_d  = S_DECIDE;
        end else begin
          cmd_o.op = OP_SCAN_READ;
          state_d  = S_CMP;
        end
      end
      S_CMP: begin
        if (stat_i.less) begin
          cmd_o.op = OP_SCAN_STEP;
          state_d  = S_RD;
        end else begin
          cmd_o.op = OP_SCAN_HIT;
          state_d  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = S_DONE;
        if (stat_i.func == FN_INSERT) begin
          if (stat_i.full) begin
            cmd_o.op = OP_SET_FULL;
          end else begin
            cmd_o.op = OP_INS_INIT;
            state_d  = S_INS_RD;
          end
        end else if (stat_i.func == FN_DELETE) begin
          if (stat_i.found) begin
            cmd_o.op = OP_DEL_INIT;
            state_d  = S_DEL_RD;
          end else begin
            cmd_o.op = OP_SET_MISS;
          end
        end
      end
      S_INS_RD: begin
        if (stat_i.ins_more) begin
          cmd_o.op = OP_INS_READ;
          state_d  = S_INS_WR;
        end else begin
          cmd_o.op = OP_INS_PUT;
          state_d  = S_DONE;
        end
      end
      S_INS_WR: begin
        cmd_o.op = OP_INS_WRITE;
        state_d  = S_INS_RD;
      end
      S_DEL_RD: begin
        if (stat_i.del_more) begin
          cmd_o.op = OP_DEL_READ;
          state_d  = S_DEL_WR;
        end else begin
          cmd_o.op = OP_DEL_END;
          state_d  = S_DONE;
        end
      end
      S_DEL_WR: begin
        cmd_o.op = OP_DEL_WRITE;
        state_d  = S_DEL_RD;
      end
      S_DONE: begin
        cmd_o.strobe = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

  // result strobe lasts a single cycle
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.strobe |=> !cmd_o.strobe)
    else $error("result strobe held for more than one cycle");

  // a request is only loaded while idle
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_LOAD) |-> !busy)
    else $error("request loaded while busy");

  // after a strobe the unit is free again
  a_strobe_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.strobe |=> !busy)
    else $error("unit still busy after result");

endmodule

// ----- design/sst_dp.sv -----
// sst_dp: entry memory, count, scan index and result registers
// depends on sst_pkg; commanded by sst_ctrl
module sst_dp import sst_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_cmd_t                  cmd_i,
  output dp_stat_t                 stat_o,
  input  logic [FUNC_W-1:0]        func_i,
  input  logic signed [DATA_W-1:0] item_i,
  output logic                     found_o,
  output logic [STAT_W-1:0]        status_o,
  output logic [COUNT_W-1:0]       entry_count_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  logic signed [DATA_W-1:0] mem_q [CAPACITY];
  logic signed [DATA_W-1:0] rdata_q;
  logic signed [DATA_W-1:0] item_q;
  logic [FUNC_W-1:0]        func_q;
  logic [CW-1:0]            count_q, scan_q, pos_q;
  logic                     found_q;
  logic [STAT_W-1:0]        status_q;

  logic                     rd_en, wr_en;
  logic [CW-1:0]            rd_idx, wr_idx;
  logic signed [DATA_W-1:0] wr_data;
  logic [CW-1:0]            scan_inc, scan_dec;

  assign scan_inc = scan_q + 1'b1;
  assign scan_dec = scan_q - 1'b1;

  // memory port selection
  always_comb begin
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    rd_idx  = scan_q;
    wr_idx  = scan_q;
    wr_data = rdata_q;
    case (cmd_i.op)
      OP_SCAN_READ: rd_en = 1'b1;
      OP_INS_READ: begin
        rd_en  = 1'b1;
        rd_idx = scan_dec;
      end
      OP_DEL_READ: begin
        rd_en  = 1'b1;
        rd_idx = scan_inc;
      end
      OP_INS_WRITE, OP_DEL_WRITE: wr_en = 1'b1;
      OP_INS_PUT: begin
        wr_en   = 1'b1;
        wr_idx  = pos_q;
        wr_data = item_q;
      end
      default: ;
    endcase
  end

  // entry memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_idx[AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_idx[AW-1:0]];
    end
  end

  // request payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      func_q <= func_i;
      item_q <= item_i;
    end
  end

  // count, index and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      scan_q   <= '0;
      pos_q    <= '0;
      found_q  <= 1'b0;
      status_q <= ST_DONE;
    end else begin
      case (cmd_i.op)
        OP_LOAD: begin
          scan_q   <= '0;
          found_q  <= 1'b0;
          status_q <= ST_DONE;
        end
        OP_SCAN_STEP: scan_q <= scan_inc;
        OP_SCAN_HIT: begin
          pos_q   <= scan_q;
          found_q <= (rdata_q == item_q);
        end
        OP_SCAN_END: begin
          pos_q   <= scan_q;
          found_q <= 1'b0;
        end
        OP_SET_FULL:  status_q <= ST_FULL;
        OP_SET_MISS:  status_q <= ST_MISS;
        OP_INS_INIT:  scan_q   <= count_q;
        OP_INS_WRITE: scan_q   <= scan_dec;
        OP_INS_PUT:   count_q  <= count_q + 1'b1;
        OP_DEL_INIT:  scan_q   <= pos_q;
        OP_DEL_WRITE: scan_q   <= scan_inc;
        OP_DEL_END:   count_q  <= count_q - 1'b1;
        default: ;
      endcase
    end
  end

  // status back to the controller
  assign stat_o.scan_end = (scan_q >= count_q);
  assign stat_o.less     = (rdata_q < item_q);
  assign stat_o.full     = (count_q >= CAP);
  assign stat_o.found    = found_q;
  assign stat_o.ins_more = (scan_q > pos_q);
  assign stat_o.del_more = (scan_inc < count_q);
  assign stat_o.func     = func_q;

  // result fields
  assign found_o       = found_q;
  assign status_o      = status_q;
  assign entry_count_o = COUNT_W'(count_q);

  // count stays within the table
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP)
    else $error("entry count above capacity");

  // an insert only lands in a table with room
  a_put_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_INS_PUT) |-> (count_q < CAP) && (pos_q <= count_q))
    else $error("insert into full table");

  // count moves by at most one per request
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == $past(count_q) + 1'b1) || (count_q == $past(count_q) - 1'b1))
    else $error("entry count jumped");

endmodule

// ----- design/sorted_set_table_unit.sv -----
// sorted_set_table_unit: ascending sorted multiset of signed 32-bit values
// depends on sst_pkg, sst_ctrl and sst_dp
//
// Usage: drive func_i and item_i and raise start; the request is taken at a
// clock edge where start is high and busy is low. func_i selects insert,
// delete or contains (the unused code acts as contains). Exactly one result
// comes back per request: found_o, status_o and entry_count_o are valid for
// the single cycle in which valid_o is high. The receiver cannot stall, so
// it must capture the result in that cycle.
// Operation: the lookup walks the stored entries one at a time through the
// entry memory, reading and then comparing each entry passed.
// Insert then shifts the larger entries up and delete shifts the tail down,
// reading and then writing each moved entry. busy stays high through the
// strobe cycle, so the next request is taken in the cycle after the strobe
// at the earliest.
// Reset: asynchronous, active low; the table comes up empty and idle. The
// entry memory is not cleared: only entries below the count are ever read.
module sorted_set_table_unit import sst_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [FUNC_W-1:0]        func_i,
  input  logic signed [DATA_W-1:0] item_i,
  output logic                     valid_o,
  output logic                     found_o,
  output logic [STAT_W-1:0]        status_o,
  output logic [COUNT_W-1:0]       entry_count_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  sst_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd),
    .stat_i (stat)
  );

  // storage and compare
  sst_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .func_i        (func_i),
    .item_i        (item_i),
    .found_o       (found_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

  assign valid_o = cmd.strobe;

endmodule
